// ===== rtl/core/r2y_pkg.sv =====
// Shared types, constants and arithmetic helpers for the RGB to YUV 4:2:0 converter.
// No dependencies; every other file of the block imports this package.
package r2y_pkg;

	// Field widths.
	localparam int PIX_W         = 8;
	localparam int CFG_W         = 13;
	localparam int CFG_INDEX_W   = 4;
	localparam int LUMA_ADDR_W   = 24;
	localparam int CHROMA_ADDR_W = 22;
	localparam int ACC_W         = 26;

	// Size limits and register reset values.
	localparam int DEF_MAX_WIDTH  = 4096;
	localparam int DEF_MAX_HEIGHT = 4096;
	localparam logic [CFG_W-1:0] RST_FRAME_WIDTH  = 13'd640;
	localparam logic [CFG_W-1:0] RST_FRAME_HEIGHT = 13'd480;

	// Configuration register indexes.
	localparam logic [CFG_INDEX_W-1:0] REG_FRAME_WIDTH  = 4'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_FRAME_HEIGHT = 4'd1;

	// Q16 coefficients, each round(c * 65536).
	localparam logic signed [ACC_W-1:0] K_YR = 26'sd19595;
	localparam logic signed [ACC_W-1:0] K_YG = 26'sd38470;
	localparam logic signed [ACC_W-1:0] K_YB = 26'sd7471;
	localparam logic signed [ACC_W-1:0] K_UR = 26'sd9642;
	localparam logic signed [ACC_W-1:0] K_UG = 26'sd18931;
	localparam logic signed [ACC_W-1:0] K_UB = 26'sd28574;
	localparam logic signed [ACC_W-1:0] K_VR = 26'sd40305;
	localparam logic signed [ACC_W-1:0] K_VG = 26'sd33750;
	localparam logic signed [ACC_W-1:0] K_VB = 26'sd6554;
	localparam logic signed [ACC_W-1:0] K_OFS = 26'sd8388608;

	// Position information of one pixel, handed from the address generator to the pipeline.
	typedef struct packed {
		logic [LUMA_ADDR_W-1:0]   luma_addr;
		logic                     chroma_valid;
		logic [CHROMA_ADDR_W-1:0] chroma_addr;
		logic                     frame_end;
	} pos_t;

	// Clamp a Q16 sum: negative gives zero, otherwise truncate and limit to 255.
	function automatic logic [PIX_W-1:0] to_byte(input logic signed [ACC_W-1:0] acc);
		logic [PIX_W-1:0] res;
		if (acc[ACC_W-1]) begin
			res = '0;
		end else if (acc[ACC_W-2:16+PIX_W] != '0) begin
			res = '1;
		end else begin
			res = acc[16+PIX_W-1:16];
		end
		return res;
	endfunction

endpackage

// ===== rtl/core/r2y_position.sv =====
// Raster position tracker: column and row counters plus the Y and U/V plane address counters.
// Depends on r2y_pkg for field widths and the pos_t struct.
module r2y_position import r2y_pkg::*; #(
	parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             step,
	input  logic [CFG_W-1:0] frame_width,
	input  logic [CFG_W-1:0] frame_height,
	output pos_t             pos
);

	localparam int CW = (MAX_WIDTH > 2) ? $clog2(MAX_WIDTH) : 1;
	localparam int RW = (MAX_HEIGHT > 2) ? $clog2(MAX_HEIGHT) : 1;
	localparam int SW = $clog2(MAX_WIDTH + 1);
	localparam int SH = $clog2(MAX_HEIGHT + 1);

	logic [CW-1:0]            col_q;
	logic [RW-1:0]            row_q;
	logic [LUMA_ADDR_W-1:0]   luma_idx_q;
	logic [CHROMA_ADDR_W-1:0] chroma_idx_q;

	logic [31:0] fw_ext;
	logic [31:0] fh_ext;
	logic [SW-1:0] w_eff;
	logic [SH-1:0] h_eff;
	logic last_col;
	logic last_row;
	logic chroma;
	logic frame_done;

	// Effective frame size, clamped to the supported range.
	always_comb begin
		fw_ext = 32'(frame_width);
		fh_ext = 32'(frame_height);
		if (fw_ext < 32'd2) begin
			w_eff = SW'(2);
		end else if (fw_ext > 32'(MAX_WIDTH)) begin
			w_eff = SW'(MAX_WIDTH);
		end else begin
			w_eff = SW'(fw_ext);
		end
		if (fh_ext < 32'd2) begin
			h_eff = SH'(2);
		end else if (fh_ext > 32'(MAX_HEIGHT)) begin
			h_eff = SH'(MAX_HEIGHT);
		end else begin
			h_eff = SH'(fh_ext);
		end
	end

	// Row and frame boundaries, and the 4:2:0 sample decision for the current pixel.
	always_comb begin
		last_col   = SW'(col_q) >= (w_eff - SW'(1));
		last_row   = SH'(row_q) >= (h_eff - SH'(1));
		frame_done = last_col && last_row;
		chroma     = !col_q[0] && !row_q[0];
		if (w_eff[0] && last_col) begin
			chroma = 1'b0;
		end
		if (h_eff[0] && last_row) begin
			chroma = 1'b0;
		end
	end

	assign pos.luma_addr    = luma_idx_q;
	assign pos.chroma_valid = chroma;
	assign pos.chroma_addr  = chroma ? chroma_idx_q : '0;
	assign pos.frame_end    = frame_done;

	// Counters step per accepted word (U/V address on chroma), cleared at frame end.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q        <= '0;
			row_q        <= '0;
			luma_idx_q   <= '0;
			chroma_idx_q <= '0;
		end else if (step) begin
			if (frame_done) begin
				col_q        <= '0;
				row_q        <= '0;
				luma_idx_q   <= '0;
				chroma_idx_q <= '0;
			end else begin
				luma_idx_q <= luma_idx_q + LUMA_ADDR_W'(1);
				if (chroma) begin
					chroma_idx_q <= chroma_idx_q + CHROMA_ADDR_W'(1);
				end
				if (last_col) begin
					col_q <= '0;
					row_q <= row_q + RW'(1);
				end else begin
					col_q <= col_q + CW'(1);
				end
			end
		end
	end

	// A finished frame leaves every counter at zero.
	assert property (@(posedge clk) disable iff (!arst_n)
		step && frame_done |=> col_q == '0 && row_q == '0 && luma_idx_q == '0)
	else $error("position counters not cleared after frame end");

	// Chroma is never taken on an odd column or an odd row.
	assert property (@(posedge clk) disable iff (!arst_n)
		chroma |-> !col_q[0] && !row_q[0])
	else $error("chroma sample flagged on an odd position");

	// A pixel without chroma carries a zero chroma address.
	assert property (@(posedge clk) disable iff (!arst_n)
		!chroma |-> pos.chroma_addr == '0)
	else $error("chroma address not zero on a luma-only pixel");

endmodule

// ===== rtl/core/r2y_csc.sv =====
// Color space conversion: Q16 fixed-point RGB to Y, U and V with saturation to 8 bits.
// Depends on r2y_pkg for coefficients and the to_byte helper.
module r2y_csc import r2y_pkg::*; (
	input  logic [PIX_W-1:0] red,
	input  logic [PIX_W-1:0] green,
	input  logic [PIX_W-1:0] blue,
	output logic [PIX_W-1:0] y,
	output logic [PIX_W-1:0] u,
	output logic [PIX_W-1:0] v
);

	logic signed [ACC_W-1:0] r_s;
	logic signed [ACC_W-1:0] g_s;
	logic signed [ACC_W-1:0] b_s;
	logic signed [ACC_W-1:0] y_acc;
	logic signed [ACC_W-1:0] u_acc;
	logic signed [ACC_W-1:0] v_acc;

	// Components as non-negative signed operands.
	assign r_s = signed'(ACC_W'(red));
	assign g_s = signed'(ACC_W'(green));
	assign b_s = signed'(ACC_W'(blue));

	// Constant-coefficient sums; every sum fits in the accumulator width exactly.
	assign y_acc = K_YR * r_s + K_YG * g_s + K_YB * b_s;
	assign u_acc = K_OFS - K_UR * r_s - K_UG * g_s + K_UB * b_s;
	assign v_acc = K_OFS + K_VR * r_s - K_VG * g_s - K_VB * b_s;

	assign y = to_byte(y_acc);
	assign u = to_byte(u_acc);
	assign v = to_byte(v_acc);

endmodule

// ===== rtl/core/rgb_to_yuv420_converter_top.sv =====
// An accepted input word passes through the input register and then the result register to the output.
// Throughput: one pixel per cycle; the input register and the result register form
// a two-stage pipeline that stalls only while the result register is held by out_ready.
// Reset (arst_n low, asynchronous): pipeline empty, position counters and addresses at
// zero, frame_width 640 and frame_height 480. Configuration writes are always accepted.
// Depends on r2y_pkg, r2y_position and r2y_csc.
module rgb_to_yuv420_converter_top import r2y_pkg::*; #(
	parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cfg_valid,
	output logic                     cfg_ready,
	input  logic [CFG_INDEX_W-1:0]   cfg_index,
	input  logic [CFG_W-1:0]         cfg_data,
	input  logic                     in_valid,
	output logic                     in_ready,
	input  logic [PIX_W-1:0]         red,
	input  logic [PIX_W-1:0]         green,
	input  logic [PIX_W-1:0]         blue,
	output logic                     out_valid,
	input  logic                     out_ready,
	output logic [PIX_W-1:0]         luma,
	output logic [LUMA_ADDR_W-1:0]   luma_address,
	output logic                     chroma_valid,
	output logic [PIX_W-1:0]         chroma_u,
	output logic [PIX_W-1:0]         chroma_v,
	output logic [CHROMA_ADDR_W-1:0] chroma_address,
	output logic                     frame_end
);

	logic [CFG_W-1:0] frame_width_q;
	logic [CFG_W-1:0] frame_height_q;

	logic in_accept;
	logic adv_s1;
	logic adv_s2;
	pos_t pos_cur;

	logic             valid_s1;
	logic [PIX_W-1:0] red_s1;
	logic [PIX_W-1:0] green_s1;
	logic [PIX_W-1:0] blue_s1;
	pos_t             pos_s1;

	logic [PIX_W-1:0] y_new;
	logic [PIX_W-1:0] u_new;
	logic [PIX_W-1:0] v_new;

	logic                     valid_s2;
	logic [PIX_W-1:0]         luma_s2;
	logic [LUMA_ADDR_W-1:0]   luma_addr_s2;
	logic                     chroma_valid_s2;
	logic [PIX_W-1:0]         chroma_u_s2;
	logic [PIX_W-1:0]         chroma_v_s2;
	logic [CHROMA_ADDR_W-1:0] chroma_addr_s2;
	logic                     frame_end_s2;

	// Configuration registers; indexes beyond the list are ignored.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_width_q  <= RST_FRAME_WIDTH;
			frame_height_q <= RST_FRAME_HEIGHT;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_FRAME_WIDTH:  frame_width_q  <= cfg_data;
				REG_FRAME_HEIGHT: frame_height_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Pipeline flow control: a stage loads when the stage after it is free or moving.
	assign adv_s2    = !valid_s2 || out_ready;
	assign adv_s1    = !valid_s1 || adv_s2;
	assign in_ready  = adv_s1;
	assign in_accept = in_valid && in_ready;

	// Position of the word being accepted.
	r2y_position #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_HEIGHT (MAX_HEIGHT)
	) u_position (
		.clk          (clk),
		.arst_n       (arst_n),
		.step         (in_accept),
		.frame_width  (frame_width_q),
		.frame_height (frame_height_q),
		.pos          (pos_cur)
	);

	// Input register stage.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (adv_s1) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_accept) begin
			red_s1   <= red;
			green_s1 <= green;
			blue_s1  <= blue;
			pos_s1   <= pos_cur;
		end
	end

	// Color conversion between the two register stages.
	r2y_csc u_csc (
		.red   (red_s1),
		.green (green_s1),
		.blue  (blue_s1),
		.y     (y_new),
		.u     (u_new),
		.v     (v_new)
	);

	// Result register stage; chroma fields read zero when no chroma is taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv_s2) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s2 && valid_s1) begin
			luma_s2         <= y_new;
			luma_addr_s2    <= pos_s1.luma_addr;
			chroma_valid_s2 <= pos_s1.chroma_valid;
			chroma_u_s2     <= pos_s1.chroma_valid ? u_new : '0;
			chroma_v_s2     <= pos_s1.chroma_valid ? v_new : '0;
			chroma_addr_s2  <= pos_s1.chroma_addr;
			frame_end_s2    <= pos_s1.frame_end;
		end
	end

	assign out_valid      = valid_s2;
	assign luma           = luma_s2;
	assign luma_address   = luma_addr_s2;
	assign chroma_valid   = chroma_valid_s2;
	assign chroma_u       = chroma_u_s2;
	assign chroma_v       = chroma_v_s2;
	assign chroma_address = chroma_addr_s2;
	assign frame_end      = frame_end_s2;

	// The input side stalls only when both stages are full and the output is held.
	assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> valid_s1 && valid_s2 && !out_ready)
	else $error("input stalled while the pipeline can move");

	// A word in the input stage that cannot move stays there.
	assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !adv_s2 |=> valid_s1 && $stable(pos_s1))
	else $error("input stage word lost during output stall");

	// Result words without chroma carry zero chroma fields.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !chroma_valid |->
			chroma_u == '0 && chroma_v == '0 && chroma_address == '0)
	else $error("chroma fields not zero on a luma-only word");

endmodule

// ===== dv/rgb_to_yuv420_converter_top_tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for rgb_to_yuv420_converter_top: a queue-fed pixel driver with its own
// Q16 color-space and 4:2:0 address predictor, a result monitor and a stall watchdog.
// Depends on r2y_pkg and the converter RTL.
module rgb_to_yuv420_converter_top_tb import r2y_pkg::*; ();

	// Q16 coefficients and offset of the conversion.
	localparam int Y_R = 19595;
	localparam int Y_G = 38470;
	localparam int Y_B = 7471;
	localparam int U_R = 9642;
	localparam int U_G = 18931;
	localparam int U_B = 28574;
	localparam int V_R = 40305;
	localparam int V_G = 33750;
	localparam int V_B = 6554;
	localparam int UV_OFFSET = 128 * 65536;
	localparam int DIM_MAX = 4096;
	localparam int WATCHDOG_LIMIT = 3000;
	localparam int LONG_HOLD_CYCLES = 300;
	localparam int PHASE_PIXELS = 450;

	typedef struct {
		logic [PIX_W-1:0] red;
		logic [PIX_W-1:0] green;
		logic [PIX_W-1:0] blue;
	} rgb_word_t;

	typedef struct {
		logic [PIX_W-1:0]         luma;
		logic [LUMA_ADDR_W-1:0]   luma_address;
		logic                     chroma_valid;
		logic [PIX_W-1:0]         chroma_u;
		logic [PIX_W-1:0]         chroma_v;
		logic [CHROMA_ADDR_W-1:0] chroma_address;
		logic                     frame_end;
	} yuv_word_t;

	logic                     clk = 1'b0;
	logic                     arst_n = 1'b0;
	logic                     cfg_valid = 1'b0;
	logic                     cfg_ready;
	logic [CFG_INDEX_W-1:0]   cfg_index = REG_FRAME_WIDTH;
	logic [CFG_W-1:0]         cfg_data = '0;
	logic                     in_valid = 1'b0;
	logic                     in_ready;
	logic [PIX_W-1:0]         red = '0;
	logic [PIX_W-1:0]         green = '0;
	logic [PIX_W-1:0]         blue = '0;
	logic                     out_valid;
	logic                     out_ready = 1'b0;
	logic [PIX_W-1:0]         luma;
	logic [LUMA_ADDR_W-1:0]   luma_address;
	logic                     chroma_valid;
	logic [PIX_W-1:0]         chroma_u;
	logic [PIX_W-1:0]         chroma_v;
	logic [CHROMA_ADDR_W-1:0] chroma_address;
	logic                     frame_end;

	// Pixels waiting to be offered, and converted words waiting to come out.
	rgb_word_t pending_pixels[$];
	yuv_word_t expected_yuv[$];
	rgb_word_t next_pixel;
	yuv_word_t want;

	// Predictor copy of the size registers and the raster position.
	logic [CFG_W-1:0]         width_setting = 13'd640;
	logic [CFG_W-1:0]         height_setting = 13'd480;
	int                       column_pos = 0;
	int                       row_pos = 0;
	logic [LUMA_ADDR_W-1:0]   next_luma_addr = '0;
	logic [CHROMA_ADDR_W-1:0] next_chroma_addr = '0;

	int send_idle_pct = 11;
	int recv_idle_pct = 66;
	int pixels_accepted = 0;
	int words_checked = 0;
	int frames_predicted = 0;
	int reg_writes = 0;
	int mismatches = 0;
	int hold_left = 0;
	bit hold_done = 1'b0;
	int stall_cycles = 0;

	rgb_to_yuv420_converter_top uut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.red           (red),
		.green         (green),
		.blue          (blue),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.luma          (luma),
		.luma_address  (luma_address),
		.chroma_valid  (chroma_valid),
		.chroma_u      (chroma_u),
		.chroma_v      (chroma_v),
		.chroma_address(chroma_address),
		.frame_end     (frame_end)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// Effective frame dimension: the register value limited to 2..4096.
	function automatic int frame_dim(input logic [CFG_W-1:0] raw);
		if (raw < 2) return 2;
		if (raw > DIM_MAX) return DIM_MAX;
		return int'(raw);
	endfunction

	// Q16 sum to a byte: negative gives zero, otherwise truncate and saturate.
	function automatic logic [PIX_W-1:0] q16_to_byte(input int acc);
		if (acc < 0) return '0;
		if ((acc >>> 16) > 255) return '1;
		return PIX_W'(acc >>> 16);
	endfunction

	// Convert one pixel and advance the raster position.
	function automatic yuv_word_t convert_pixel(input logic [PIX_W-1:0] r8, g8, b8);
		yuv_word_t res;
		int r, g, b, w, h;
		bit last_col, last_row, has_chroma, frame_done;
		r = int'(r8);
		g = int'(g8);
		b = int'(b8);
		w = frame_dim(width_setting);
		h = frame_dim(height_setting);
		last_col = column_pos >= w - 1;
		last_row = row_pos >= h - 1;
		frame_done = last_col && last_row;
		has_chroma = (column_pos % 2 == 0) && (row_pos % 2 == 0);
		// An odd last column or row has no partner sample, so it carries no chroma.
		if ((w % 2 == 1) && last_col) has_chroma = 1'b0;
		if ((h % 2 == 1) && last_row) has_chroma = 1'b0;
		res.luma = q16_to_byte(Y_R * r + Y_G * g + Y_B * b);
		res.luma_address = next_luma_addr;
		res.chroma_valid = has_chroma;
		res.chroma_u = has_chroma ? q16_to_byte(UV_OFFSET - U_R * r - U_G * g + U_B * b) : '0;
		res.chroma_v = has_chroma ? q16_to_byte(UV_OFFSET + V_R * r - V_G * g - V_B * b) : '0;
		res.chroma_address = has_chroma ? next_chroma_addr : '0;
		res.frame_end = frame_done;
		if (frame_done) begin
			column_pos = 0;
			row_pos = 0;
			next_luma_addr = '0;
			next_chroma_addr = '0;
			frames_predicted++;
		end else begin
			next_luma_addr = next_luma_addr + 1'b1;
			if (has_chroma) next_chroma_addr = next_chroma_addr + 1'b1;
			if (last_col) begin
				column_pos = 0;
				row_pos++;
			end else begin
				column_pos++;
			end
		end
		return res;
	endfunction

	// Channel value with extra weight on the saturation corners.
	function automatic logic [PIX_W-1:0] rand_channel();
		if ($urandom_range(0, 7) == 0) return $urandom_range(0, 1) ? 8'hFF : 8'h00;
		return PIX_W'($urandom_range(0, 255));
	endfunction

	task automatic queue_pixel(input logic [PIX_W-1:0] r, g, b);
		rgb_word_t px;
		px.red = r;
		px.green = g;
		px.blue = b;
		pending_pixels.push_back(px);
	endtask

	// Register write; returns at the following falling edge.
	task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_W-1:0] val);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		@(negedge clk);
		reg_writes++;
		if (idx == REG_FRAME_WIDTH) width_setting = val;
		else if (idx == REG_FRAME_HEIGHT) height_setting = val;
	endtask

	// Hold off until every queued pixel has been converted and checked.
	task automatic wait_drained();
		do @(negedge clk); while (pending_pixels.size() != 0 || in_valid
			|| expected_yuv.size() != 0);
	endtask

	function automatic logic [CFG_W-1:0] rand_dim();
		case ($urandom_range(0, 9))
			0: return CFG_W'($urandom_range(0, 1));
			1: return CFG_W'($urandom_range(64, (1 << CFG_W) - 1));
			default: return CFG_W'($urandom_range(2, 9));
		endcase
	endfunction

	// Random sizes, each fed whole frames plus up to 3 pixels or, for big sizes, a partial one.
	task automatic random_frames(input int budget);
		int sent, area, burst;
		sent = 0;
		while (sent < budget) begin
			if ($urandom_range(0, 5) != 0) write_reg(REG_FRAME_WIDTH, rand_dim());
			if ($urandom_range(0, 5) != 0) write_reg(REG_FRAME_HEIGHT, rand_dim());
			// Writes to unassigned indexes must leave the size alone.
			if ($urandom_range(0, 9) == 0) begin
				write_reg(CFG_INDEX_W'($urandom_range(REG_FRAME_HEIGHT + 1,
					(1 << CFG_INDEX_W) - 1)), CFG_W'($urandom));
			end
			area = frame_dim(width_setting) * frame_dim(height_setting);
			if (area > 100) burst = $urandom_range(1, 40);
			else burst = area * $urandom_range(1, 3) + $urandom_range(0, 3);
			repeat (burst) queue_pixel(rand_channel(), rand_channel(), rand_channel());
			sent += burst;
			wait_drained();
		end
	endtask

	// Driver: offers queued pixels and predicts each word at acceptance.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			if (in_valid && in_ready) begin
				expected_yuv.push_back(convert_pixel(red, green, blue));
				pixels_accepted++;
			end
			if (!in_valid || in_ready) begin
				if (pending_pixels.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
					next_pixel = pending_pixels.pop_front();
					in_valid <= 1'b1;
					red <= next_pixel.red;
					green <= next_pixel.green;
					blue <= next_pixel.blue;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Monitor: checks each result word against the oldest prediction and drives out_ready.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (out_valid && out_ready) begin
				words_checked++;
				if (expected_yuv.size() == 0) begin
					mismatches++;
					if (mismatches <= 10) begin
						$display("ERROR: result word with nothing expected: luma %0d addr %0d",
							luma, luma_address);
					end
				end else begin
					want = expected_yuv.pop_front();
					if (luma !== want.luma || luma_address !== want.luma_address
						|| chroma_valid !== want.chroma_valid || chroma_u !== want.chroma_u
						|| chroma_v !== want.chroma_v || chroma_address !== want.chroma_address
						|| frame_end !== want.frame_end) begin
						mismatches++;
						if (mismatches <= 10) begin
							$display("ERROR: word %0d expected y %0d ya %0d cv %0d u %0d v %0d ca %0d fe %0d",
								words_checked, want.luma, want.luma_address, want.chroma_valid,
								want.chroma_u, want.chroma_v, want.chroma_address, want.frame_end);
							$display("       got            y %0d ya %0d cv %0d u %0d v %0d ca %0d fe %0d",
								luma, luma_address, chroma_valid, chroma_u, chroma_v,
								chroma_address, frame_end);
						end
					end
				end
			end
			// One long hold while the sender keeps offering, so the pipeline backs up.
			if (hold_left > 0) begin
				hold_left--;
				out_ready <= 1'b0;
			end else if (!hold_done && words_checked >= 300 && in_valid) begin
				hold_done = 1'b1;
				hold_left = LONG_HOLD_CYCLES - 1;
				out_ready <= 1'b0;
			end else begin
				out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
			end
		end
	end

	// Watchdog: ends the run when no word moves on any channel for too long.
	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready)
			|| (cfg_valid && cfg_ready)) begin
			stall_cycles <= 0;
		end else if (stall_cycles == WATCHDOG_LIMIT) begin
			$display("ERROR: no progress for %0d cycles", WATCHDOG_LIMIT);
			$display("FAIL rgb_to_yuv420_converter_top");
			$finish;
		end else begin
			stall_cycles <= stall_cycles + 1;
		end
	end

	// Stimulus sequence.
	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Reset size 640x480 with color corners: black, white, saturated V, max U and two with negative V.
		queue_pixel(8'h00, 8'h00, 8'h00);
		queue_pixel(8'hFF, 8'hFF, 8'hFF);
		queue_pixel(8'hFF, 8'h00, 8'h00);
		queue_pixel(8'h00, 8'h00, 8'hFF);
		queue_pixel(8'h00, 8'hFF, 8'hFF);
		queue_pixel(8'h00, 8'hFF, 8'h00);
		wait_drained();

		// Sizes below the minimum clamp to 2x2 while the column is already past the end.
		write_reg(REG_FRAME_WIDTH, 13'd0);
		write_reg(REG_FRAME_HEIGHT, 13'd1);
		queue_pixel(8'h00, 8'h00, 8'hFF);
		queue_pixel(8'hFF, 8'h00, 8'hFF);
		queue_pixel(8'h80, 8'h7F, 8'h01);
		queue_pixel(8'hFF, 8'h00, 8'h00);
		wait_drained();

		// Odd width and height drop chroma on the last column and row.
		write_reg(REG_FRAME_WIDTH, 13'd3);
		write_reg(REG_FRAME_HEIGHT, 13'd3);
		repeat (9) queue_pixel(rand_channel(), rand_channel(), rand_channel());
		wait_drained();

		// Oversize clamps to 4096; then the width and the height shrink mid-frame.
		write_reg(REG_FRAME_WIDTH, 13'd8191);
		write_reg(REG_FRAME_HEIGHT, 13'd8191);
		repeat (2) queue_pixel(rand_channel(), rand_channel(), rand_channel());
		wait_drained();
		write_reg(REG_FRAME_WIDTH, 13'd2);
		repeat (2) queue_pixel(rand_channel(), rand_channel(), rand_channel());
		wait_drained();
		write_reg(REG_FRAME_HEIGHT, 13'd2);
		repeat (2) queue_pixel(rand_channel(), rand_channel(), rand_channel());
		wait_drained();

		random_frames(PHASE_PIXELS);
		send_idle_pct = 66;
		recv_idle_pct = 11;
		random_frames(PHASE_PIXELS);
		send_idle_pct = 0;
		recv_idle_pct = 0;
		random_frames(PHASE_PIXELS);

		repeat (10) @(posedge clk);
		if (expected_yuv.size() != 0) begin
			mismatches++;
			$display("ERROR: %0d result words never arrived", expected_yuv.size());
		end
		$display("Run covered %0d pixels, %0d frame ends and %0d register writes.",
			pixels_accepted, frames_predicted, reg_writes);
		$display("Checked %0d result words under three idle patterns and one long output stall.",
			words_checked);
		if (mismatches == 0) begin
			$display("PASS rgb_to_yuv420_converter_top");
		end else begin
			$display("%0d mismatches in total", mismatches);
			$display("FAIL rgb_to_yuv420_converter_top");
		end
		$finish;
	end

endmodule

// ===== files.f =====
rtl/core/r2y_pkg.sv
rtl/core/r2y_position.sv
rtl/core/r2y_csc.sv
rtl/core/rgb_to_yuv420_converter_top.sv
dv/rgb_to_yuv420_converter_top_tb.sv
